@@ rtl/tcsq_pkg.sv @@
// Shared types for the two-class service queue: action codes, the cell command and the cell-to-cell chain struct.
`timescale 1ns / 1ps

package tcsq_pkg;

  // Action codes carried on the action input field
  typedef enum logic [1:0] {
    ACT_INSERT       = 2'd0,
    ACT_SERVE_PREF   = 2'd1,
    ACT_SERVE_OLDEST = 2'd2,
    ACT_WITHDRAW     = 2'd3
  } tcsq_action_t;

  // Command broadcast from the control logic to every cell
  typedef struct packed {
    logic ins_ok;   // append the new entry at the first free cell
    logic rm_pref;  // remove the oldest preferential entry
    logic rm_head;  // remove the oldest entry of all
    logic rm_id;    // remove the entry whose id matches the key
  } tcsq_cmd_t;

  // Flags handed from each cell to its right neighbor
  typedef struct packed {
    logic head;       // set only into the oldest cell
    logic prev_valid; // the left neighbor holds an entry
    logic pref_seen;  // a preferential entry sits further left
    logic hit_seen;   // an entry with the key sits further left
    logic rm_seen;    // the removed entry is at or left of here
    logic gone_pref;  // the removed entry was preferential
  } tcsq_chain_t;

endpackage

@@ rtl/tcsq_cell.sv @@
// One queue slot: holds an entry, compares it against the key and closes gaps.
`timescale 1ns / 1ps

module tcsq_cell #(
  parameter int ID_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcsq_pkg::tcsq_cmd_t  cmd,
  input  logic [ID_BITS-1:0]   key,
  input  logic                 new_pref,
  input  tcsq_pkg::tcsq_chain_t chain_in,
  output tcsq_pkg::tcsq_chain_t chain_out,
  input  logic [ID_BITS-1:0]   id_acc_in,
  output logic [ID_BITS-1:0]   id_acc_out,
  input  logic                 nxt_valid,
  input  logic [ID_BITS-1:0]   nxt_id,
  input  logic                 nxt_pref,
  output logic                 slot_valid,
  output logic [ID_BITS-1:0]   slot_id,
  output logic                 slot_pref
);
  import tcsq_pkg::*;

  logic own_pref;
  logic own_hit;
  logic target;
  logic shift;
  logic load_new;

  // Compare this slot and decide whether it is the one to remove
  always_comb begin
    own_pref = slot_valid & slot_pref;
    own_hit  = slot_valid & (slot_id == key);
    target   = (cmd.rm_pref & own_pref & ~chain_in.pref_seen)
             | (cmd.rm_head & chain_in.head)
             | (cmd.rm_id & own_hit);
    shift    = chain_in.rm_seen | target;
    load_new = cmd.ins_ok & chain_in.prev_valid & ~slot_valid;
  end

  // Pass flags and the served id on to the right neighbor
  always_comb begin
    chain_out.head       = 1'b0;
    chain_out.prev_valid = slot_valid;
    chain_out.pref_seen  = chain_in.pref_seen | own_pref;
    chain_out.hit_seen   = chain_in.hit_seen | own_hit;
    chain_out.rm_seen    = shift;
    chain_out.gone_pref  = chain_in.gone_pref | (target & slot_pref);
    id_acc_out           = id_acc_in | (target ? slot_id : '0);
  end

  // Advance from the right neighbor on removal, take the new entry on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (shift) begin
      slot_valid <= nxt_valid;
    end else if (load_new) begin
      slot_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      slot_id   <= nxt_id;
      slot_pref <= nxt_pref;
    end else if (load_new) begin
      slot_id   <= key;
      slot_pref <= new_pref;
    end
  end

endmodule

@@ rtl/two_class_service_queue.sv @@
// Top level of the two-class service queue: control, count registers and the cell row.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall): one action per transfer: insert an id
//   with a preferential flag, serve the oldest preferential entry (or the oldest
//   entry if none is preferential), serve the oldest entry, or withdraw an id.
// - Output channel (out_valid / out_stall): exactly one result per action:
//   success, served_id (0 unless a serve succeeded), and the total and
//   preferential counts after the action.
// - The result is registered at the edge that takes the action. Throughput is
//   one action per cycle while in_stall is low; the row of DEPTH cells
//   compares every slot against the key and closes a gap in that same cycle.
// - A stalled result holds in the output register; in_stall is raised while a
//   result waits and out_stall is high, so no action is taken until it leaves.
// - Synchronous reset empties the queue (slot valid bits and the counts
//   clear); stored ids are only read behind their valid bits.
module two_class_service_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] person_id,
  input  logic        is_preferential,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success,
  output logic [15:0] served_id,
  output logic [4:0]  total_count,
  output logic [4:0]  preferential_count
);
  import tcsq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic              acc;
  logic [ID_BITS-1:0] key;
  tcsq_action_t      act;
  tcsq_cmd_t         cmd;
  logic [CW-1:0]     cnt_total;
  logic [CW-1:0]     cnt_pref;
  logic [CW-1:0]     cnt_total_next;
  logic [CW-1:0]     cnt_pref_next;
  logic              full;
  logic              ok;
  logic [ID_BITS-1:0] served_full;
  logic [15:0]       served_w;
  logic [4:0]        total_w;
  logic [4:0]        pref_w;
  logic              ins_ok;

  tcsq_chain_t        chain  [DEPTH+1];
  logic [ID_BITS-1:0] id_acc [DEPTH+1];
  logic               cell_valid [DEPTH];
  logic [ID_BITS-1:0] cell_id    [DEPTH];
  logic               cell_pref  [DEPTH];
  logic [DEPTH-1:0]   vld_vec;

  // Hold the input while a finished result waits downstream
  assign in_stall = out_valid & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign act      = tcsq_action_t'(action);
  assign full     = (cnt_total == CW'(DEPTH));

  // Fit the id to ID_BITS
  generate
    if (ID_BITS >= 16) begin : g_key_wide
      assign key = ID_BITS'(person_id);
    end else begin : g_key_narrow
      assign key = person_id[ID_BITS-1:0];
    end
  endgenerate

  // Seed the chain at the oldest cell
  assign chain[0] = '{head: 1'b1, prev_valid: 1'b1, pref_seen: 1'b0,
                      hit_seen: 1'b0, rm_seen: 1'b0, gone_pref: 1'b0};
  assign id_acc[0] = '0;

  // Decode the action into the cell command
  always_comb begin
    ins_ok = 1'b0;
    cmd    = '0;
    ok     = 1'b0;
    unique case (act)
      ACT_INSERT: begin
        ins_ok     = ~full & ~chain[DEPTH].hit_seen;
        cmd.ins_ok = acc & ins_ok;
        ok         = ins_ok;
      end
      ACT_SERVE_PREF: begin
        cmd.rm_pref = acc & (cnt_pref != '0);
        cmd.rm_head = acc & (cnt_pref == '0) & (cnt_total != '0);
        ok          = (cnt_total != '0);
      end
      ACT_SERVE_OLDEST: begin
        cmd.rm_head = acc & (cnt_total != '0);
        ok          = (cnt_total != '0);
      end
      ACT_WITHDRAW: begin
        cmd.rm_id = acc;
        ok        = chain[DEPTH].hit_seen;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Row of cells, each shifting in from its right neighbor
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               r_valid;
      logic [ID_BITS-1:0] r_id;
      logic               r_pref;
      if (i == DEPTH - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_id    = '0;
        assign r_pref  = 1'b0;
      end else begin : g_mid
        assign r_valid = cell_valid[i+1];
        assign r_id    = cell_id[i+1];
        assign r_pref  = cell_pref[i+1];
      end

      tcsq_cell #(
        .ID_BITS(ID_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .key       (key),
        .new_pref  (is_preferential),
        .chain_in  (chain[i]),
        .chain_out (chain[i+1]),
        .id_acc_in (id_acc[i]),
        .id_acc_out(id_acc[i+1]),
        .nxt_valid (r_valid),
        .nxt_id    (r_id),
        .nxt_pref  (r_pref),
        .slot_valid(cell_valid[i]),
        .slot_id   (cell_id[i]),
        .slot_pref (cell_pref[i])
      );

      assign vld_vec[i] = cell_valid[i];
    end
  endgenerate

  // Track the counts for the action just taken
  always_comb begin
    cnt_total_next = cnt_total;
    cnt_pref_next  = cnt_pref;
    if (cmd.ins_ok) begin
      cnt_total_next = cnt_total + CW'(1);
      cnt_pref_next  = cnt_pref + CW'(is_preferential);
    end else if (chain[DEPTH].rm_seen) begin
      cnt_total_next = cnt_total - CW'(1);
      cnt_pref_next  = cnt_pref - CW'(chain[DEPTH].gone_pref);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_total <= '0;
      cnt_pref  <= '0;
    end else if (acc) begin
      cnt_total <= cnt_total_next;
      cnt_pref  <= cnt_pref_next;
    end
  end

  // Fit the served id and counts to the result fields
  assign served_full = ((act == ACT_SERVE_PREF) || (act == ACT_SERVE_OLDEST))
                     ? id_acc[DEPTH] : '0;
  generate
    if (ID_BITS >= 16) begin : g_srv_wide
      assign served_w = served_full[15:0];
    end else begin : g_srv_narrow
      assign served_w = 16'(served_full);
    end
    if (CW >= 5) begin : g_cnt_wide
      assign total_w = cnt_total_next[4:0];
      assign pref_w  = cnt_pref_next[4:0];
    end else begin : g_cnt_narrow
      assign total_w = 5'(cnt_total_next);
      assign pref_w  = 5'(cnt_pref_next);
    end
  endgenerate

  // Load the result register on a transfer, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      success            <= ok;
      served_id          <= ok ? served_w : '0;
      total_count        <= total_w;
      preferential_count <= pref_w;
    end
  end

`ifndef SYNTHESIS
  a_pref_le_total: assert property (@(posedge clk) disable iff (rst)
    cnt_pref <= cnt_total)
    else $error("preferential count exceeds total count");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_total <= CW'(DEPTH))
    else $error("total count exceeds depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(cnt_total))
    else $error("occupied slots disagree with total count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted action produced no result");

  a_served_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (served_id == 16'd0))
    else $error("failed action reports a served id");
`endif

endmodule
